/* rtl/eo3_pkg.sv */
// eo3_pkg: shared types, constants and kernel tables for the 3x3 edge operator.
// Used by eo3_lane, eo3_merge and edge_operator_3x3_top; depends on nothing.
package eo3_pkg;

	// default pixel width
	localparam int PIXEL_BITS_DEF = 8;

	// kernel coefficient width, signed, holds -32..31; the table values span -20..10
	localparam int COEF_W = 6;

	// taps in one window
	localparam int TAPS = 9;

	// result width and saturation limit
	localparam int EDGE_W = 8;
	localparam logic [EDGE_W-1:0] EDGE_MAX = 8'd255;

	typedef enum logic [1:0] {
		OP_SOBEL     = 2'd0,
		OP_PREWITT   = 2'd1,
		OP_SCHARR    = 2'd2,
		OP_LAPLACIAN = 2'd3
	} op_kind_t;

	typedef logic signed [COEF_W-1:0] coef_t;

	// horizontal kernels, row major; the Laplacian kernel rides in this lane
	localparam coef_t GX_TAB [4][TAPS] = '{
		'{-6'sd1, 6'sd0, 6'sd1, -6'sd2, 6'sd0, 6'sd2, -6'sd1, 6'sd0, 6'sd1},
		'{-6'sd1, 6'sd0, 6'sd1, -6'sd1, 6'sd0, 6'sd1, -6'sd1, 6'sd0, 6'sd1},
		'{-6'sd3, 6'sd0, 6'sd3, -6'sd10, 6'sd0, 6'sd10, -6'sd3, 6'sd0, 6'sd3},
		'{6'sd1, 6'sd4, 6'sd1, 6'sd4, -6'sd20, 6'sd4, 6'sd1, 6'sd4, 6'sd1}
	};

	// vertical kernels; all zero for the Laplacian
	localparam coef_t GY_TAB [4][TAPS] = '{
		'{6'sd1, 6'sd2, 6'sd1, 6'sd0, 6'sd0, 6'sd0, -6'sd1, -6'sd2, -6'sd1},
		'{-6'sd1, -6'sd1, -6'sd1, 6'sd0, 6'sd0, 6'sd0, 6'sd1, 6'sd1, 6'sd1},
		'{-6'sd3, -6'sd10, -6'sd3, 6'sd0, 6'sd0, 6'sd0, 6'sd3, 6'sd10, 6'sd3},
		'{6'sd0, 6'sd0, 6'sd0, 6'sd0, 6'sd0, 6'sd0, 6'sd0, 6'sd0, 6'sd0}
	};

endpackage

/* rtl/eo3_lane.sv */
// eo3_lane: one weighted-sum lane over a 3x3 window (products, row sums, total).
// Depends on eo3_pkg; instantiated twice by edge_operator_3x3_top.
module eo3_lane #(
	parameter int PIXEL_BITS = eo3_pkg::PIXEL_BITS_DEF,
	parameter int SUM_W      = PIXEL_BITS + eo3_pkg::COEF_W + 4
) (
	input  logic                     clk,
	input  logic [PIXEL_BITS-1:0]    pix  [eo3_pkg::TAPS],
	input  eo3_pkg::coef_t           coef [eo3_pkg::TAPS],
	output logic signed [SUM_W-1:0]  sum_s3
);

	localparam int PROD_W = PIXEL_BITS + eo3_pkg::COEF_W;
	localparam int FULL_W = PIXEL_BITS + 1 + eo3_pkg::COEF_W;
	localparam int ROW_W  = PROD_W + 2;

	logic signed [FULL_W-1:0] prod_full [eo3_pkg::TAPS];
	logic signed [PROD_W-1:0] prod_s1   [eo3_pkg::TAPS];
	logic signed [ROW_W-1:0]  row_s2    [3];

	// form the tap products as pixel times signed coefficient
	always_comb begin
		for (int i = 0; i < eo3_pkg::TAPS; i++) begin
			prod_full[i] = $signed({1'b0, pix[i]}) * coef[i];
		end
	end

	// register the products
	always_ff @(posedge clk) begin
		for (int i = 0; i < eo3_pkg::TAPS; i++) begin
			prod_s1[i] <= prod_full[i][PROD_W-1:0];
		end
	end

	// add each window row
	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			row_s2[r] <= ROW_W'(prod_s1[3*r]) + ROW_W'(prod_s1[3*r+1])
				+ ROW_W'(prod_s1[3*r+2]);
		end
	end

	// add the three rows
	always_ff @(posedge clk) begin
		sum_s3 <= SUM_W'(row_s2[0]) + SUM_W'(row_s2[1]) + SUM_W'(row_s2[2]);
	end

endmodule

/* rtl/eo3_merge.sv */
// eo3_merge: combines the two lane sums into |Gx|+|Gy|, saturated, registered.
// Depends on eo3_pkg; instantiated by edge_operator_3x3_top.
module eo3_merge #(
	parameter int SUM_W = eo3_pkg::PIXEL_BITS_DEF + eo3_pkg::COEF_W + 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic signed [SUM_W-1:0]          sx_s3,
	input  logic signed [SUM_W-1:0]          sy_s3,
	output logic [eo3_pkg::EDGE_W-1:0]       edge_q
);

	logic [SUM_W-1:0] abs_x;
	logic [SUM_W-1:0] abs_y;
	logic [SUM_W:0]   mag;

	// take magnitudes and add them
	always_comb begin
		abs_x = sx_s3[SUM_W-1] ? SUM_W'(-sx_s3) : SUM_W'(sx_s3);
		abs_y = sy_s3[SUM_W-1] ? SUM_W'(-sy_s3) : SUM_W'(sy_s3);
		mag   = {1'b0, abs_x} + {1'b0, abs_y};
	end

	// clamp at the limit and register the result
	always_ff @(posedge clk) begin
		if (mag > (SUM_W+1)'(eo3_pkg::EDGE_MAX)) begin
			edge_q <= eo3_pkg::EDGE_MAX;
		end else begin
			edge_q <= mag[eo3_pkg::EDGE_W-1:0];
		end
	end

	// two zero sums give a zero result
	a_zero_in_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		(sx_s3 == '0 && sy_s3 == '0) |=> (edge_q == '0))
		else $error("nonzero edge value from zero sums");

	// a magnitude over the limit gives exactly the saturation limit
	a_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(mag > (SUM_W+1)'(eo3_pkg::EDGE_MAX)) |=> (edge_q == eo3_pkg::EDGE_MAX))
		else $error("edge value not saturated");

endmodule

/* rtl/edge_operator_3x3_top.sv */
// edge_operator_3x3_top: 3x3 Sobel/Prewitt/Scharr/Laplacian edge operator.
// Depends on eo3_pkg, eo3_lane and eo3_merge.
//
// One window is taken on every clock edge where start is high; busy is always
// low. Each window gives one edge_value, marked by a one-cycle done strobe.
// The window passes through the lane pipeline registers (products, row sums,
// window sum) and then the magnitude/saturation register. Results are not held:
// the receiver must take each one in the cycle done is high. Write
// operator_kind through cfg_we/cfg_wdata only while no window is in flight.
module edge_operator_3x3_top #(
	parameter int PIXEL_BITS = eo3_pkg::PIXEL_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_wdata,
	input  logic [PIXEL_BITS-1:0]       pix_top_left,
	input  logic [PIXEL_BITS-1:0]       pix_top_mid,
	input  logic [PIXEL_BITS-1:0]       pix_top_right,
	input  logic [PIXEL_BITS-1:0]       pix_mid_left,
	input  logic [PIXEL_BITS-1:0]       pix_center,
	input  logic [PIXEL_BITS-1:0]       pix_mid_right,
	input  logic [PIXEL_BITS-1:0]       pix_bot_left,
	input  logic [PIXEL_BITS-1:0]       pix_bot_mid,
	input  logic [PIXEL_BITS-1:0]       pix_bot_right,
	output logic                        done,
	output logic [eo3_pkg::EDGE_W-1:0]  edge_value
);

	localparam int SUM_W = PIXEL_BITS + eo3_pkg::COEF_W + 4;

	eo3_pkg::op_kind_t          kind_q;
	logic [PIXEL_BITS-1:0]      pix   [eo3_pkg::TAPS];
	eo3_pkg::coef_t             gx_coef [eo3_pkg::TAPS];
	eo3_pkg::coef_t             gy_coef [eo3_pkg::TAPS];
	logic signed [SUM_W-1:0]    sx_s3;
	logic signed [SUM_W-1:0]    sy_s3;
	logic                       vld_s1;
	logic                       vld_s2;
	logic                       vld_s3;
	logic                       vld_s4;

	// never stall the input
	assign busy = 1'b0;

	// hold the operator selection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= eo3_pkg::OP_SOBEL;
		end else if (cfg_we) begin
			kind_q <= eo3_pkg::op_kind_t'(cfg_wdata);
		end
	end

	// gather the window in row-major order
	assign pix[0] = pix_top_left;
	assign pix[1] = pix_top_mid;
	assign pix[2] = pix_top_right;
	assign pix[3] = pix_mid_left;
	assign pix[4] = pix_center;
	assign pix[5] = pix_mid_right;
	assign pix[6] = pix_bot_left;
	assign pix[7] = pix_bot_mid;
	assign pix[8] = pix_bot_right;

	// look up the kernels for the selected operator
	always_comb begin
		for (int i = 0; i < eo3_pkg::TAPS; i++) begin
			gx_coef[i] = eo3_pkg::GX_TAB[kind_q][i];
			gy_coef[i] = eo3_pkg::GY_TAB[kind_q][i];
		end
	end

	eo3_lane #(
		.PIXEL_BITS (PIXEL_BITS),
		.SUM_W      (SUM_W)
	) u_lane_x (
		.clk    (clk),
		.pix    (pix),
		.coef   (gx_coef),
		.sum_s3 (sx_s3)
	);

	eo3_lane #(
		.PIXEL_BITS (PIXEL_BITS),
		.SUM_W      (SUM_W)
	) u_lane_y (
		.clk    (clk),
		.pix    (pix),
		.coef   (gy_coef),
		.sum_s3 (sy_s3)
	);

	eo3_merge #(
		.SUM_W (SUM_W)
	) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.sx_s3  (sx_s3),
		.sy_s3  (sy_s3),
		.edge_q (edge_value)
	);

	// advance the transaction valid flags alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign done = vld_s4;

	// every accepted window yields a done strobe
	a_start_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("accepted transaction produced no result");

	// no result without an accepted window
	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 4))
		else $error("result strobe without a transaction");

endmodule
